FILE: rtl/svdp_pkg.sv
package svdp_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 1024;
    localparam int VECTOR_BITS   = 32;
    localparam int QUEUE_DEPTH   = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // field widths
    localparam int CMD_W   = 2;
    localparam int PC_W    = 32;
    localparam int DIST_W  = 6;
    localparam int MASK_W  = 32;
    localparam int COUNT_W = 32;

    // older-store count saturates at the smaller of queue depth and vector length
    localparam int OLDER_LIMIT = (QUEUE_DEPTH < VECTOR_BITS) ? QUEUE_DEPTH : VECTOR_BITS;

    localparam logic [COUNT_W-1:0] CLEAR_PERIOD_RESET = COUNT_W'(250000);

    // command codes
    localparam logic [CMD_W-1:0] CMD_VIOLATION = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK     = 2'd2;

    typedef logic [VECTOR_BITS-1:0] t_vector;
    typedef logic [IDX_W-1:0]       t_index;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PC_W-1:0]   load_pc;
        logic [DIST_W-1:0] store_distance;
        logic [DIST_W-1:0] older_stores;
    } t_item;

    typedef struct packed {
        logic [MASK_W-1:0] dependence_mask;
        logic              distance_error;
        logic              table_cleared;
    } t_result;

endpackage

FILE: rtl/store_vector_dependence_predictor.sv
// the accepted beat passes stage one, then the result registers that drive the result strobe
// throughput: one beat per cycle while busy is low; the receiver cannot stall the result
// an insert that clears the table holds busy while it is in stage one and
// through a clearing pass over all 1024 table entries, one entry per cycle
// reset is synchronous, active low; after reset the same clearing pass
// runs with busy high, and clear_period returns to 250000
module store_vector_dependence_predictor (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  svdp_pkg::t_item                      i_item,
    input  logic                                 i_cfg_we,
    input  logic [svdp_pkg::COUNT_W-1:0]         i_cfg_wdata,
    output logic                                 o_valid,
    output svdp_pkg::t_result                    o_result
);

    // table memory, one store vector per entry
    svdp_pkg::t_vector mem [svdp_pkg::TABLE_ENTRIES];

    logic                           accept;
    svdp_pkg::t_index               in_idx;

    // stage one: accepted beat with its table read
    logic                           r_s1_valid;
    svdp_pkg::t_item                r_s1_item;
    svdp_pkg::t_index               r_s1_idx;
    svdp_pkg::t_vector              r_mem_q;
    logic                           r_fwd;
    svdp_pkg::t_vector              r_fwd_data;
    svdp_pkg::t_vector              s1_vec;

    // clearing pass
    logic                           r_sweep;
    svdp_pkg::t_index               r_sweep_idx;

    // counter and register
    logic [svdp_pkg::COUNT_W-1:0]   r_op_count;
    logic [svdp_pkg::COUNT_W-1:0]   n_op_count;
    logic [svdp_pkg::COUNT_W-1:0]   r_clear_period;
    logic                           s1_insert;
    logic                           s1_clear;

    // violation update
    logic                           dist_bad;
    logic                           s1_wr_en;
    svdp_pkg::t_vector              s1_wr_data;

    // check mask
    logic [svdp_pkg::DIST_W-1:0]    older_sat;
    svdp_pkg::t_vector              low_mask;

    svdp_pkg::t_result              n_result;

    // result beat registers
    logic                           r_valid;
    svdp_pkg::t_result              r_result;

    assign accept = start && !busy;
    // power-of-two table: modulo is the low bits
    assign in_idx = i_item.load_pc[svdp_pkg::IDX_W-1:0];

    // read data with bypass of a write landing on the same edge
    assign s1_vec = r_fwd ? r_fwd_data : r_mem_q;

    // op counter compare
    assign s1_insert  = r_s1_valid && (r_s1_item.command == svdp_pkg::CMD_INSERT);
    assign n_op_count = r_op_count + svdp_pkg::COUNT_W'(1);
    assign s1_clear   = s1_insert && (n_op_count > r_clear_period);

    assign busy = r_sweep || s1_clear;

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // distance check and bit set
    assign dist_bad = (r_s1_item.store_distance == '0) ||
        ({1'b0, r_s1_item.store_distance} > (svdp_pkg::DIST_W+1)'(svdp_pkg::VECTOR_BITS));
    assign s1_wr_en = r_s1_valid && (r_s1_item.command == svdp_pkg::CMD_VIOLATION) && !dist_bad;
    assign s1_wr_data = s1_vec |
        (svdp_pkg::t_vector'(1) << (r_s1_item.store_distance - svdp_pkg::DIST_W'(1)));

    // older-store saturation and low mask
    always_comb begin
        if ({1'b0, r_s1_item.older_stores} > (svdp_pkg::DIST_W+1)'(svdp_pkg::OLDER_LIMIT)) begin
            older_sat = svdp_pkg::DIST_W'(svdp_pkg::OLDER_LIMIT);
        end else begin
            older_sat = r_s1_item.older_stores;
        end
        if ({1'b0, older_sat} >= (svdp_pkg::DIST_W+1)'(svdp_pkg::VECTOR_BITS)) begin
            low_mask = '1;
        end else begin
            low_mask = (svdp_pkg::t_vector'(1) << older_sat) - svdp_pkg::t_vector'(1);
        end
    end

    // result of the beat in stage one
    always_comb begin
        n_result = '0;
        unique case (r_s1_item.command)
            svdp_pkg::CMD_VIOLATION: begin
                n_result.distance_error = dist_bad;
            end
            svdp_pkg::CMD_INSERT: begin
                n_result.table_cleared = s1_clear;
            end
            svdp_pkg::CMD_CHECK: begin
                n_result.dependence_mask = svdp_pkg::MASK_W'(s1_vec & low_mask);
            end
            default: begin
                n_result = '0;
            end
        endcase
    end

    // memory write and read port
    always_ff @(posedge i_clk) begin
        if (r_sweep) begin
            mem[r_sweep_idx] <= '0;
        end else if (s1_wr_en) begin
            mem[r_s1_idx] <= s1_wr_data;
        end
        r_mem_q <= mem[in_idx];
    end

    // stage one payload and forwarding, and the result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item  <= i_item;
            r_s1_idx   <= in_idx;
            r_fwd      <= s1_wr_en && (r_s1_idx == in_idx);
            r_fwd_data <= s1_wr_data;
        end
        r_result <= n_result;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_valid        <= 1'b0;
            r_sweep        <= 1'b1;
            r_sweep_idx    <= '0;
            r_op_count     <= '0;
            r_clear_period <= svdp_pkg::CLEAR_PERIOD_RESET;
        end else begin
            r_s1_valid <= accept;
            r_valid    <= r_s1_valid;
            if (i_cfg_we) begin
                r_clear_period <= i_cfg_wdata;
            end
            // count inserts, restart on clear
            if (s1_clear) begin
                r_op_count <= '0;
            end else if (s1_insert) begin
                r_op_count <= n_op_count;
            end
            // clearing pass over every entry
            if (s1_clear) begin
                r_sweep     <= 1'b1;
                r_sweep_idx <= '0;
            end else if (r_sweep) begin
                if (r_sweep_idx == svdp_pkg::IDX_W'(svdp_pkg::TABLE_ENTRIES - 1)) begin
                    r_sweep <= 1'b0;
                end
                r_sweep_idx <= r_sweep_idx + svdp_pkg::IDX_W'(1);
            end
        end
    end

endmodule

FILE: rtl/svdp_checker.sv
module svdp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input svdp_pkg::t_item               i_item,
    input logic                          i_cfg_we,
    input logic [svdp_pkg::COUNT_W-1:0]  i_cfg_wdata,
    input logic                          o_valid,
    input svdp_pkg::t_result             o_result
);

    // reset starts the clearing pass
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy not raised after reset");

    // every accepted beat gives a result once it has passed stage one and the result registers
    a_beat_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted beat lost its result");

    // no result without an accepted beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without accepted beat");

    // busy is high, holding off new beats for the clearing pass, when the result of a clear shows
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.table_cleared) |-> busy)
        else $error("not busy during table clear");

    // a clearing insert reports nothing else
    a_clear_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.table_cleared) |->
            (o_result.dependence_mask == '0 && !o_result.distance_error))
        else $error("clear result carries other fields");

endmodule

bind store_vector_dependence_predictor svdp_checker u_svdp_checker (.*);
